>>> rtl/continuous_phase_carrier_nco_assert.svh
// Assertion macros shared by the checker files of the carrier oscillator.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef CONTINUOUS_PHASE_CARRIER_NCO_ASSERT_SVH
`define CONTINUOUS_PHASE_CARRIER_NCO_ASSERT_SVH

// Same-cycle implication, masked while reset is low.
`define CPNCO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is low.
`define CPNCO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that stays live through reset.
`define CPNCO_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cpnco_pkg.sv
// Package of the continuous-phase carrier oscillator: widths, codes, types
// and the quarter-wave sine generator used to build the lookup table.
// No dependencies.
`default_nettype none

package cpnco_pkg;

  localparam int unsigned MAX_BATCH_DEF       = 64;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 10;
  localparam int unsigned SAMPLE_BITS_DEF     = 16;

  localparam int unsigned FREQ_W     = 32;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned BATCH_W    = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = 32'd1;
  localparam logic [BATCH_W-1:0] BATCH_LEN_RST   = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_LENGTH = 2'd1;

  // power of two, pointers wrap naturally
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_GEN  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_RUN
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic              neg;
    logic [FREQ_W-1:0] mag;
    logic [PHASE_W-1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [FREQ_W-1:0] mag;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [PHASE_W-1:0] step;
  } div_rsp_t;

  // round(amp * sin(pi/2 * k / 2^addr_bits)) by a Q30 Taylor series to x^13.
  // Evaluated at elaboration only.
  function automatic logic [31:0] quarter_sine(int unsigned k, int unsigned addr_bits,
                                               int unsigned sample_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] t5;
    logic [63:0] t6;
    logic [63:0] amp;
    logic [63:0] v;
    longint      sum;
    x   = (PI_HALF_Q30 * 64'(k)) >> addr_bits;
    x2  = (x * x) >> 30;
    t1  = ((x  * x2) >> 30) / 64'd6;
    t2  = ((t1 * x2) >> 30) / 64'd20;
    t3  = ((t2 * x2) >> 30) / 64'd42;
    t4  = ((t3 * x2) >> 30) / 64'd72;
    t5  = ((t4 * x2) >> 30) / 64'd110;
    t6  = ((t5 * x2) >> 30) / 64'd156;
    sum = longint'(x) - longint'(t1) + longint'(t2) - longint'(t3)
          + longint'(t4) - longint'(t5) + longint'(t6);
    if (sum < 0) begin
      sum = 0;
    end
    amp = (64'd1 << (sample_bits - 1)) - 64'd1;
    v   = (64'(sum) * amp + (64'd1 << 29)) >> 30;
    if (v > amp) begin
      v = amp;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/cpnco_if.sv
// Channel interfaces of the carrier oscillator: request, sample and config.
// Depends on cpnco_pkg for field widths.
`default_nettype none

interface cpnco_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   operation;
  logic signed [cpnco_pkg::FREQ_W-1:0]    freq_hz;
  logic        [cpnco_pkg::PHASE_W-1:0]   phase_value;

  modport source (output valid, output operation, output freq_hz, output phase_value,
                  input ready);
  modport sink (input valid, input operation, input freq_hz, input phase_value,
                output ready);
endinterface

interface cpnco_out_if #(
  parameter int unsigned SAMPLE_BITS = cpnco_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] i_sample;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic                          last;

  modport source (output valid, output i_sample, output q_sample, output last,
                  input ready);
  modport sink (input valid, input i_sample, input q_sample, input last,
                output ready);
endinterface

interface cpnco_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cpnco_pkg::CFG_IDX_W-1:0]     index;
  logic [cpnco_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/cpnco_front.sv
// Front end: accepts request beats and turns them into queue commands
// (operation, frequency sign and magnitude, phase). Uses cpnco_pkg, cpnco_if.
`default_nettype none

module cpnco_front (
  cpnco_in_if.sink          in_ch,
  input  logic              fifo_full,
  output logic              push,
  output cpnco_pkg::cmd_t   cmd
);

  logic [cpnco_pkg::FREQ_W-1:0] freq_bits;

  assign freq_bits   = $unsigned(in_ch.freq_hz);
  assign in_ch.ready = !fifo_full;
  assign push        = in_ch.valid && !fifo_full;

  always_comb begin
    cmd.op    = cpnco_pkg::op_t'(in_ch.operation);
    cmd.neg   = freq_bits[cpnco_pkg::FREQ_W-1];
    // two's complement magnitude; the most negative value maps onto itself
    cmd.mag   = cmd.neg ? (cpnco_pkg::FREQ_W'(0) - freq_bits) : freq_bits;
    cmd.phase = in_ch.phase_value;
  end

endmodule

`default_nettype wire

>>> rtl/cpnco_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Uses cpnco_pkg for the command type and depth.
`default_nettype none

module cpnco_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cpnco_pkg::cmd_t   wr_cmd,
  output logic              full,
  input  logic              pop,
  output cpnco_pkg::cmd_t   rd_cmd,
  output logic              empty
);

  localparam int unsigned DEPTH = cpnco_pkg::CMD_FIFO_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cpnco_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cpnco_step_div.sv
// Bit-serial restoring divider for the phase step: (mag << 32) / rate,
// one quotient bit per cycle, low 32 bits kept, sign applied at the end.
// Uses cpnco_pkg for widths and request/response types.
`default_nettype none

module cpnco_step_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [cpnco_pkg::RATE_W-1:0]    rate,
  input  cpnco_pkg::div_req_t             req,
  output cpnco_pkg::div_rsp_t             rsp
);

  localparam int unsigned W     = cpnco_pkg::PHASE_W;
  localparam int unsigned STEPS = 2 * W;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     dvd_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     rate_r;
  logic             neg_r;

  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             ge;

  // shift the next dividend bit in; zeros follow once the magnitude is used up
  assign trial = {rem_r, dvd_r[W-1]};
  assign diff  = trial - {1'b0, rate_r};
  assign ge    = (trial >= {1'b0, rate_r});

  assign rsp.done = done_r;
  assign rsp.step = neg_r ? (W'(0) - quo_r) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      dvd_r  <= req.mag;
      quo_r  <= '0;
      rate_r <= rate;
      neg_r  <= req.neg;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> rtl/cpnco_back.sv
// Back end: pops commands, loads the phase or runs the step division, then walks the phase
// accumulator through the quarter-wave table into a two-stage sample pipe.
// Uses cpnco_pkg, cpnco_if; drives the divider through div_req/div_rsp.
`default_nettype none

module cpnco_back #(
  parameter int unsigned MAX_BATCH       = cpnco_pkg::MAX_BATCH_DEF,
  parameter int unsigned TABLE_ADDR_BITS = cpnco_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = cpnco_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cpnco_pkg::cmd_t                   cmd,
  input  logic                              fifo_empty,
  output logic                              pop,
  input  logic [cpnco_pkg::BATCH_W-1:0]     batch_length,
  output cpnco_pkg::div_req_t               div_req,
  input  cpnco_pkg::div_rsp_t               div_rsp,
  cpnco_out_if.source                       out_ch
);

  localparam int unsigned TAB   = TABLE_ADDR_BITS;
  localparam int unsigned P_W   = TAB + 2;
  localparam int unsigned MAG_W = SAMPLE_BITS - 1;
  localparam int unsigned CNT_W = $clog2(MAX_BATCH + 1);
  localparam int unsigned PW    = cpnco_pkg::PHASE_W;
  localparam int unsigned BW    = cpnco_pkg::BATCH_W;
  localparam logic [TAB:0]    N_ENT   = (TAB + 1)'(1) << TAB;
  localparam logic [BW-1:0]   MAX_CNT = BW'(MAX_BATCH);

  cpnco_pkg::bk_state_t state_r;
  cpnco_pkg::bk_state_t state_nxt;
  logic [PW-1:0]        phase_r;
  logic [PW-1:0]        phase_nxt;
  logic [PW-1:0]        step_r;
  logic [PW-1:0]        step_nxt;
  logic [CNT_W-1:0]     left_r;
  logic [CNT_W-1:0]     left_nxt;
  logic                 issue;

  logic [BW-1:0]        batch_cnt;
  logic [P_W-1:0]       p;
  logic [1:0]           quad;
  logic [1:0]           cquad;
  logic [TAB:0]         r_ext;
  logic [TAB:0]         sin_addr;
  logic [TAB:0]         cos_addr;

  logic [MAG_W-1:0]     sine_rom [0:(1 << TAB)];

  logic                 s1_v_r;
  logic [MAG_W-1:0]     sin_mag_r;
  logic [MAG_W-1:0]     cos_mag_r;
  logic                 sin_neg_r;
  logic                 cos_neg_r;
  logic                 s1_last_r;
  logic                 s1_free;

  logic                   out_v_r;
  logic [SAMPLE_BITS-1:0] out_i_r;
  logic [SAMPLE_BITS-1:0] out_q_r;
  logic                   out_last_r;
  logic                   out_load;
  logic [SAMPLE_BITS-1:0] cos_ext;
  logic [SAMPLE_BITS-1:0] sin_ext;

  for (genvar k = 0; k <= (1 << TAB); k++) begin : g_rom
    assign sine_rom[k] = MAG_W'(cpnco_pkg::quarter_sine(k, TAB, SAMPLE_BITS));
  end

  assign batch_cnt = (batch_length > MAX_CNT) ? MAX_CNT : batch_length;

  // table address: quadrant picks direction and sign, cosine is a quarter ahead
  assign p        = phase_r[PW-1 -: P_W];
  assign quad     = p[TAB+1:TAB];
  assign cquad    = quad + 2'd1;
  assign r_ext    = {1'b0, p[TAB-1:0]};
  assign sin_addr = quad[0]  ? (N_ENT - r_ext) : r_ext;
  assign cos_addr = cquad[0] ? (N_ENT - r_ext) : r_ext;

  assign out_load = s1_v_r && (!out_v_r || out_ch.ready);
  assign s1_free  = !s1_v_r || out_load;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    left_nxt  = left_r;
    pop       = 1'b0;
    issue     = 1'b0;
    div_req   = '0;
    unique case (state_r)
      cpnco_pkg::BK_IDLE: begin
        if (!fifo_empty) begin
          pop = 1'b1;
          if (cmd.op == cpnco_pkg::OP_LOAD) begin
            phase_nxt = cmd.phase;
          end else begin
            div_req.start = 1'b1;
            div_req.neg   = cmd.neg;
            div_req.mag   = cmd.mag;
            left_nxt      = CNT_W'(batch_cnt);
            state_nxt     = cpnco_pkg::BK_DIV;
          end
        end
      end
      cpnco_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          step_nxt  = div_rsp.step;
          state_nxt = (left_r == '0) ? cpnco_pkg::BK_IDLE : cpnco_pkg::BK_RUN;
        end
      end
      cpnco_pkg::BK_RUN: begin
        // advance only when the table stage can take the beat
        if (s1_free) begin
          issue     = 1'b1;
          phase_nxt = phase_r + step_r;
          left_nxt  = left_r - CNT_W'(1);
          if (left_r == CNT_W'(1)) begin
            state_nxt = cpnco_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = cpnco_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpnco_pkg::BK_IDLE;
      phase_r <= '0;
      step_r  <= '0;
      left_r  <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      left_r  <= left_nxt;
      if (s1_free) begin
        s1_v_r <= issue;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      sin_mag_r <= sine_rom[sin_addr];
      cos_mag_r <= sine_rom[cos_addr];
      sin_neg_r <= quad[1];
      cos_neg_r <= cquad[1];
      s1_last_r <= (left_r == CNT_W'(1));
    end
  end

  assign cos_ext = {1'b0, cos_mag_r};
  assign sin_ext = {1'b0, sin_mag_r};

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_i_r    <= cos_neg_r ? (SAMPLE_BITS'(0) - cos_ext) : cos_ext;
      out_q_r    <= sin_neg_r ? (SAMPLE_BITS'(0) - sin_ext) : sin_ext;
      out_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.i_sample = $signed(out_i_r);
  assign out_ch.q_sample = $signed(out_q_r);
  assign out_ch.last     = out_last_r;

endmodule

`default_nettype wire

>>> rtl/continuous_phase_carrier_nco.sv
// Continuous-phase quadrature carrier oscillator, top level.
// Depends on cpnco_pkg, cpnco_if, cpnco_front, cpnco_cmd_fifo, cpnco_step_div, cpnco_back.
//
// Channels: in_ch takes requests (operation 0 loads the 32-bit phase from
// phase_value, operation 1 generates one batch at freq_hz). out_ch returns
// cos/sin samples, last set on the final sample of a batch. cfg_ch writes
// sample_rate (index 0) and batch_length (index 1); it is always ready and
// should be written only while the block is idle.
// Flow: a generate request leaves the queue, passes through the bit-serial
// step divider (one quotient bit per cycle over 64 bits), then through the
// table read and the output register before its first sample; samples then
// stream at one per cycle while out_ch.ready stays high. Up to two requests
// wait in the command queue, so in_ch keeps accepting while a batch is in
// progress until the queue is full.
// Reset: phase and step clear to zero, sample_rate to 1, batch_length to 64,
// queue and pipeline empty. No clearing pass is needed.
// Stall: when out_ch.ready is low the output register holds its sample and
// the phase accumulator stops once the table stage is full; no sample is lost or repeated.
`default_nettype none

module continuous_phase_carrier_nco #(
  parameter int unsigned MAX_BATCH       = cpnco_pkg::MAX_BATCH_DEF,
  parameter int unsigned TABLE_ADDR_BITS = cpnco_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = cpnco_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  cpnco_in_if.sink     in_ch,
  cpnco_out_if.source  out_ch,
  cpnco_cfg_if.sink    cfg_ch
);

  logic [cpnco_pkg::RATE_W-1:0]  sample_rate_r;
  logic [cpnco_pkg::BATCH_W-1:0] batch_length_r;
  logic [cpnco_pkg::RATE_W-1:0]  rate_eff;

  logic                  push;
  logic                  pop;
  logic                  fifo_full;
  logic                  fifo_empty;
  cpnco_pkg::cmd_t       wr_cmd;
  cpnco_pkg::cmd_t       rd_cmd;
  cpnco_pkg::div_req_t   div_req;
  cpnco_pkg::div_rsp_t   div_rsp;

  assign cfg_ch.ready = 1'b1;

  // a zero rate divides as one
  assign rate_eff = (sample_rate_r == '0) ? cpnco_pkg::RATE_W'(1) : sample_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r  <= cpnco_pkg::SAMPLE_RATE_RST;
      batch_length_r <= cpnco_pkg::BATCH_LEN_RST;
    end else if (cfg_ch.valid) begin
      priority if (cfg_ch.index == cpnco_pkg::REG_SAMPLE_RATE) begin
        sample_rate_r <= cfg_ch.data[cpnco_pkg::RATE_W-1:0];
      end else if (cfg_ch.index == cpnco_pkg::REG_BATCH_LENGTH) begin
        batch_length_r <= cfg_ch.data[cpnco_pkg::BATCH_W-1:0];
      end else begin
        // unknown index: drop the write
      end
    end
  end

  cpnco_front u_front (
    .in_ch     (in_ch),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd       (wr_cmd)
  );

  cpnco_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .full   (fifo_full),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .empty  (fifo_empty)
  );

  cpnco_step_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .rate  (rate_eff),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  cpnco_back #(
    .MAX_BATCH       (MAX_BATCH),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (rd_cmd),
    .fifo_empty   (fifo_empty),
    .pop          (pop),
    .batch_length (batch_length_r),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/cpnco_checker.sv
// Port-level checker for the carrier oscillator, bound to the top level.
// Depends on cpnco_pkg and continuous_phase_carrier_nco_assert.svh.
`default_nettype none

`include "continuous_phase_carrier_nco_assert.svh"

module cpnco_checker #(
  parameter int unsigned SAMPLE_BITS = cpnco_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_i,
  input logic [SAMPLE_BITS-1:0] out_q,
  input logic                   out_last
);

  `CPNCO_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "sample beat dropped under stall")
  `CPNCO_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_i) && $stable(out_q) && $stable(out_last), "sample beat changed under stall")
  `CPNCO_ASSERT_RST(a_rst_clear, !rst_n, !out_valid, "output valid after reset")
  `CPNCO_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind continuous_phase_carrier_nco cpnco_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cpnco_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_i     (out_ch.i_sample),
  .out_q     (out_ch.q_sample),
  .out_last  (out_ch.last)
);

`default_nettype wire

>>> bench/continuous_phase_carrier_nco_tb.sv
// Self-checking bench for the continuous-phase quadrature carrier oscillator.
// Predicts every cos/sin beat from its own sine table and phase accumulator.
// Depends on cpnco_pkg, cpnco_if and the continuous_phase_carrier_nco top.
`default_nettype none

module continuous_phase_carrier_nco_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_BITS   = cpnco_pkg::TABLE_ADDR_BITS_DEF;
  localparam int unsigned TBL_SIZE   = 1 << TBL_BITS;
  localparam int unsigned AMPLITUDE  = (1 << (cpnco_pkg::SAMPLE_BITS_DEF - 1)) - 1;
  localparam int unsigned BATCH_CAP  = cpnco_pkg::MAX_BATCH_DEF;
  localparam int unsigned SETTLE_CYC = 300;
  localparam int unsigned HOLD_CYC   = 600;
  localparam longint      CYCLE_CAP  = 3_000_000;

  typedef struct packed {
    logic signed [15:0] i_sample;
    logic signed [15:0] q_sample;
    logic               last;
  } carrier_sample_t;

  // Tracks the oscillator phase and queues the cos/sin beats it must emit.
  class carrier_scoreboard;
    int              sine_q[TBL_SIZE + 1];
    bit [31:0]       rate;
    bit [6:0]        blen;
    bit [31:0]       phase_acc;
    bit [31:0]       step;
    carrier_sample_t queued_samples[$];
    int              mismatches;

    function new();
      for (int k = 0; k <= TBL_SIZE; k++) begin
        sine_q[k] = quarter_wave(k);
      end
      rate       = cpnco_pkg::SAMPLE_RATE_RST;
      blen       = cpnco_pkg::BATCH_LEN_RST;
      phase_acc  = '0;
      step       = '0;
      mismatches = 0;
    endfunction

    // Q30 Taylor series of sin(pi/2 * k/N), rounded half up and clamped.
    function int quarter_wave(int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      x    = (cpnco_pkg::PI_HALF_Q30 * longint'(k)) / TBL_SIZE;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (longint'(sum) * AMPLITUDE + (64'd1 << 29)) >> 30;
      if (v > AMPLITUDE) begin
        v = AMPLITUDE;
      end
      return int'(v);
    endfunction

    function logic signed [15:0] wave_at(bit [TBL_BITS+1:0] p);
      int r;
      r = int'(p[TBL_BITS-1:0]);
      case (p[TBL_BITS+1:TBL_BITS])
        2'd0:    return 16'(sine_q[r]);
        2'd1:    return 16'(sine_q[TBL_SIZE - r]);
        2'd2:    return 16'(-sine_q[r]);
        default: return 16'(-sine_q[TBL_SIZE - r]);
      endcase
    endfunction

    function bit [31:0] freq_to_step(bit [31:0] freq);
      bit [31:0] divisor;
      bit [31:0] mag;
      bit [63:0] quo;
      divisor = (rate == 0) ? 32'd1 : rate;
      mag     = freq[31] ? (32'd0 - freq) : freq;
      quo     = {mag, 32'd0} / {32'd0, divisor};
      return freq[31] ? (32'd0 - quo[31:0]) : quo[31:0];
    endfunction

    function void note_config(logic [cpnco_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == cpnco_pkg::REG_SAMPLE_RATE) begin
        rate = data;
      end else if (idx == cpnco_pkg::REG_BATCH_LENGTH) begin
        blen = data[6:0];
      end
    endfunction

    function void note_request(cpnco_pkg::op_t op, logic [31:0] freq, logic [31:0] phase_in);
      int unsigned           count;
      bit [TBL_BITS+1:0]     p;
      carrier_sample_t       s;
      if (op == cpnco_pkg::OP_LOAD) begin
        phase_acc = phase_in;
        return;
      end
      step  = freq_to_step(freq);
      count = (blen > BATCH_CAP) ? BATCH_CAP : blen;
      for (int k = 0; k < count; k++) begin
        p          = phase_acc[31:30-TBL_BITS];
        s.i_sample = wave_at(p + (TBL_BITS+2)'(TBL_SIZE));
        s.q_sample = wave_at(p);
        s.last     = (k == count - 1);
        queued_samples.push_back(s);
        phase_acc  = phase_acc + step;
      end
    endfunction

    function void check_sample(logic signed [15:0] i_got, logic signed [15:0] q_got,
                               logic last_got);
      carrier_sample_t want;
      if (queued_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected beat: i=%0d q=%0d last=%0b", i_got, q_got, last_got);
        end
        return;
      end
      want = queued_samples.pop_front();
      if (want.i_sample !== i_got || want.q_sample !== q_got || want.last !== last_got) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("beat mismatch: exp i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                   want.i_sample, want.q_sample, want.last, i_got, q_got, last_got);
        end
      end
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  longint cycle_count = 0;
  bit     src_quiet;
  bit     sink_quiet;
  bit     sink_hold_req;

  carrier_scoreboard board;

  cpnco_in_if  in_ch();
  cpnco_out_if out_ch();
  cpnco_cfg_if cfg_ch();

  continuous_phase_carrier_nco dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_request(cpnco_pkg::op_t op, logic [31:0] freq, logic [31:0] phase_in);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.freq_hz     <= freq;
    in_ch.phase_value <= phase_in;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(op, freq, phase_in);
  endtask

  task automatic write_reg(logic [cpnco_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.note_config(idx, data);
  endtask

  // Drop valid and wait until every queued beat is out.
  task automatic drain_samples();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.queued_samples.size() != 0);
  endtask

  // A load or a zero-length batch leaves no beat to wait for, so pad with cycles.
  task automatic settle_block();
    drain_samples();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] rate, logic [6:0] blen, logic [24:0] pad);
    settle_block();
    write_reg(cpnco_pkg::REG_SAMPLE_RATE, rate);
    write_reg(cpnco_pkg::REG_BATCH_LENGTH, {pad, blen});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_freq();
    logic [31:0] mag;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3, 4: begin
        mag = $urandom_range(0, 100000);
        return ($urandom_range(0, 1) == 1) ? (32'd0 - mag) : mag;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
    endcase
  endfunction

  // Sink: random ready gaps, one long hold on request.
  initial begin
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin : sink_loop
      int unsigned gap;
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end
      gap = sink_quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      board.check_sample(out_ch.i_sample, out_ch.q_sample, out_ch.last);
    end
  end

  initial begin
    logic [31:0]    rate;
    logic [6:0]     blen;
    cpnco_pkg::op_t op;

    board             = new();
    src_quiet         = 1'b0;
    sink_quiet        = 1'b0;
    sink_hold_req     = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= cpnco_pkg::OP_LOAD;
    in_ch.freq_hz     <= '0;
    in_ch.phase_value <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= cpnco_pkg::REG_SAMPLE_RATE;
    cfg_ch.data       <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, a full batch at phase zero.
    send_request(cpnco_pkg::OP_GEN, 32'd0, 32'hFFFF_FFFF);

    // Zero sample rate acts as one; single-beat batches.
    program_regs(32'd0, 7'd1, '0);
    send_request(cpnco_pkg::OP_GEN, 32'h7FFF_FFFF, 32'd0);
    send_request(cpnco_pkg::OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(cpnco_pkg::OP_GEN, 32'd1, 32'h0);

    // Quarter-cycle steps walk all quadrants, both directions.
    program_regs(32'd48000, 7'd3, '1);
    send_request(cpnco_pkg::OP_LOAD, 32'h1234_5678, 32'd0);
    send_request(cpnco_pkg::OP_GEN, 32'd12000, 32'hFFFF_FFFF);
    send_request(cpnco_pkg::OP_GEN, -32'sd12000, 32'h5555_5555);
    send_request(cpnco_pkg::OP_GEN, 32'h8000_0000, 32'hAAAA_AAAA);
    send_request(cpnco_pkg::OP_GEN, 32'h7FFF_FFFF, 32'd0);
    send_request(cpnco_pkg::OP_LOAD, 32'h8000_0000, 32'h4000_0000);
    send_request(cpnco_pkg::OP_GEN, 32'd7, 32'hFFFF_FFFF);

    // Empty batch: phase holds while the step is still taken.
    program_regs(32'hFFFF_FFFF, 7'd0, '0);
    send_request(cpnco_pkg::OP_GEN, 32'd1000, 32'd0);
    send_request(cpnco_pkg::OP_LOAD, 32'd0, 32'h1234_5678);
    send_request(cpnco_pkg::OP_GEN, 32'hFFFF_FFFF, 32'd0);

    // Oversized batch lengths saturate.
    program_regs(32'd4, 7'd127, '0);
    send_request(cpnco_pkg::OP_GEN, 32'd1, 32'd0);
    send_request(cpnco_pkg::OP_LOAD, 32'd0, 32'd0);
    send_request(cpnco_pkg::OP_GEN, -32'sd2, 32'd0);
    program_regs(32'd3, 7'd65, '0);
    send_request(cpnco_pkg::OP_GEN, 32'd3, 32'd0);

    // Random phases.
    for (int ph = 0; ph < 9; ph++) begin
      rate = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(8000, 20_000_000);
      case ($urandom_range(0, 9))
        0:       blen = 7'd0;
        1:       blen = 7'($urandom_range(65, 127));
        2, 3:    blen = 7'($urandom_range(9, 64));
        default: blen = 7'($urandom_range(1, 8));
      endcase
      if (ph == 3) begin
        blen = 7'd16;
      end
      program_regs(rate, blen, 25'($urandom));
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      if (ph == 3) begin
        // fill the block while the sink holds off
        src_quiet     = 1'b1;
        sink_hold_req = 1'b1;
      end
      for (int n = 0; n < 56; n++) begin
        if (ph == 5 && n == 28) begin
          drain_samples();
        end
        if ($urandom_range(0, 9) < 3) begin
          op = cpnco_pkg::OP_LOAD;
        end else begin
          op = cpnco_pkg::OP_GEN;
        end
        send_request(op, pick_freq(), $urandom);
      end
    end

    settle_block();
    if (board.mismatches == 0 && board.queued_samples.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
